### rtl/core/ple_pkg.sv
// Shared constants, command and status codes, and sequencer states for the list engine.
`default_nettype none

package ple_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 8;
	localparam int LEN_W  = 8;
	localparam int STAT_W = 3;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = POS_W + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_INS_POS   = 3'd2,
		CMD_REM_FRONT = 3'd3,
		CMD_REM_BACK  = 3'd4,
		CMD_REM_POS   = 3'd5,
		CMD_SEARCH    = 3'd6
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_EMPTY    = 3'd1,
		STAT_BADPOS   = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_UP,
		ST_PLACE,
		ST_SHIFT_DOWN,
		ST_SEARCH,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### rtl/core/ple_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/core/positional_list_engine.sv
// Top level of the positional list engine: command sequencer and entry RAM.
//
// Usage: an ordered list of up to DEPTH signed 32-bit values held in a RAM.
// Command channel (cmd_valid / cmd_stall) carries cmd, value and position;
// response channel (rsp_valid / rsp_stall) returns status, removed_value,
// found_position and length, exactly one response per command.
// A command is taken only while the sequencer is idle; it then owns the
// single RAM read port and walks the entries one per cycle. An insert
// moves the entries from its index onward up by one, then writes the value;
// a remove reads from its index, keeps the removed word and moves the rest
// down; a search reads from the front until a match or the end. Rejected or
// unknown commands and a search of an empty list go straight to the final
// state. The next command can be taken in the same cycle that the response
// appears. The walk is paced by the RAM's registered read.
// The response sits in an output register, so a new command may be taken
// while it waits; a finished command waits in its final state while
// rsp_stall is high and the previous response is still pending.
// Reset empties the list at once (stored length zero); stored words are not cleared.
`default_nettype none

module positional_list_engine (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_stall,
	input  wire logic [ple_pkg::CMD_W-1:0]         cmd,
	input  wire logic signed [ple_pkg::DATA_W-1:0] value,
	input  wire logic [ple_pkg::POS_W-1:0]         position,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic [ple_pkg::STAT_W-1:0]             status,
	output logic signed [ple_pkg::DATA_W-1:0]      removed_value,
	output logic [ple_pkg::POS_W-1:0]              found_position,
	output logic [ple_pkg::LEN_W-1:0]              length
);

	import ple_pkg::*;

	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [DATA_W-1:0]   val_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    rd_left_q;
	logic                rd_vld_q;
	logic                first_q;
	logic [IDX_W-1:0]    wa_q;
	status_t             st_q;
	logic [DATA_W-1:0]   rem_q;
	logic [POS_W-1:0]    fnd_q;

	logic                rsp_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [DATA_W-1:0]   removed_q;
	logic [POS_W-1:0]    found_q;
	logic [LEN_W-1:0]    length_q;

	cmd_t                cmd_in;
	status_t             acc_st;
	state_t              acc_next;
	logic [IDX_W-1:0]    acc_idx;
	logic [IDX_W-1:0]    acc_ptr;
	logic [CNT_W-1:0]    acc_left;
	logic [CMP_W-1:0]    pos9;
	logic [CMP_W-1:0]    cnt9;
	logic                is_full;
	logic                is_empty;

	logic                issue;
	logic                walk_end;
	logic                match;
	logic                commit;
	logic [IDX_W-1:0]    wa_next;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic [DATA_W-1:0]   ram_rdata;

	ple_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// decode an incoming command against the current length
	always_comb begin
		cmd_in   = cmd_t'(cmd);
		pos9     = {1'b0, position};
		cnt9     = CMP_W'(count_q);
		is_full  = (count_q == CNT_W'(DEPTH));
		is_empty = (count_q == '0);
		acc_st   = STAT_OK;
		acc_next = ST_DONE;
		acc_idx  = '0;
		case (cmd_in)
			CMD_INS_FRONT: begin
				if (is_full) begin
					acc_st = STAT_FULL;
				end else begin
					acc_next = ST_SHIFT_UP;
				end
			end
			CMD_INS_BACK: begin
				if (is_full) begin
					acc_st = STAT_FULL;
				end else begin
					acc_idx  = IDX_W'(count_q);
					acc_next = ST_SHIFT_UP;
				end
			end
			CMD_INS_POS: begin
				if (pos9 == '0 || pos9 > cnt9 + CMP_W'(1)) begin
					acc_st = STAT_BADPOS;
				end else if (is_full) begin
					acc_st = STAT_FULL;
				end else begin
					acc_idx  = IDX_W'(position - POS_W'(1));
					acc_next = ST_SHIFT_UP;
				end
			end
			CMD_REM_FRONT: begin
				if (is_empty) begin
					acc_st = STAT_EMPTY;
				end else begin
					acc_next = ST_SHIFT_DOWN;
				end
			end
			CMD_REM_BACK: begin
				if (is_empty) begin
					acc_st = STAT_EMPTY;
				end else begin
					acc_idx  = IDX_W'(count_q - CNT_W'(1));
					acc_next = ST_SHIFT_DOWN;
				end
			end
			CMD_REM_POS: begin
				if (is_empty) begin
					acc_st = STAT_EMPTY;
				end else if (pos9 == '0 || pos9 > cnt9) begin
					acc_st = STAT_BADPOS;
				end else begin
					acc_idx  = IDX_W'(position - POS_W'(1));
					acc_next = ST_SHIFT_DOWN;
				end
			end
			CMD_SEARCH: begin
				acc_st = STAT_NOTFOUND;
				if (!is_empty) begin
					acc_next = ST_SEARCH;
				end
			end
			default: begin
				acc_st = STAT_OK;
			end
		endcase
		acc_left = count_q - CNT_W'(acc_idx);
		acc_ptr  = (acc_next == ST_SHIFT_UP) ? IDX_W'(count_q - CNT_W'(1)) : acc_idx;
	end

	// walk control shared by shifts and search
	assign issue    = (state_q == ST_SHIFT_UP || state_q == ST_SHIFT_DOWN ||
	                   state_q == ST_SEARCH) && (rd_left_q != '0);
	assign walk_end = (rd_left_q == '0) && !rd_vld_q;
	assign match    = (state_q == ST_SEARCH) && rd_vld_q && (ram_rdata == val_q);
	assign commit   = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = acc_next;
				end
			end
			ST_SHIFT_UP: begin
				if (walk_end) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				state_d = ST_DONE;
			end
			ST_SHIFT_DOWN: begin
				if (walk_end) begin
					state_d = ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (match || walk_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// RAM write port and next write address
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = ram_rdata;
		wa_next   = rd_ptr_q;
		case (state_q)
			ST_SHIFT_UP: begin
				ram_we  = rd_vld_q;
				wa_next = rd_ptr_q + IDX_W'(1);
			end
			ST_SHIFT_DOWN: begin
				ram_we  = rd_vld_q && !first_q;
				wa_next = rd_ptr_q - IDX_W'(1);
			end
			ST_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = val_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_vld_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= issue;
			if (commit) begin
				rsp_valid_q <= 1'b1;
				if (st_q == STAT_OK) begin
					if (cmd_q == CMD_INS_FRONT || cmd_q == CMD_INS_BACK ||
					    cmd_q == CMD_INS_POS) begin
						count_q <= count_q + CNT_W'(1);
					end else if (cmd_q == CMD_REM_FRONT || cmd_q == CMD_REM_BACK ||
					             cmd_q == CMD_REM_POS) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers: latch command, advance walk, collect results
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q     <= cmd_in;
			val_q     <= value;
			idx_q     <= acc_idx;
			st_q      <= acc_st;
			rd_ptr_q  <= acc_ptr;
			rd_left_q <= acc_left;
			rem_q     <= '0;
			fnd_q     <= '0;
		end
		if (issue) begin
			rd_ptr_q  <= (state_q == ST_SHIFT_UP) ? rd_ptr_q - IDX_W'(1)
			                                      : rd_ptr_q + IDX_W'(1);
			rd_left_q <= match ? '0 : rd_left_q - CNT_W'(1);
			wa_q      <= wa_next;
			first_q   <= (rd_ptr_q == idx_q);
		end
		if (state_q == ST_SHIFT_DOWN && rd_vld_q && first_q) begin
			rem_q <= ram_rdata;
		end
		if (match) begin
			st_q  <= STAT_OK;
			fnd_q <= POS_W'({1'b0, wa_q}) + POS_W'(1);
		end
		if (commit) begin
			status_q  <= st_q;
			removed_q <= rem_q;
			found_q   <= fnd_q;
			length_q  <= LEN_W'(state_q == ST_DONE && st_q == STAT_OK &&
			             (cmd_q == CMD_INS_FRONT || cmd_q == CMD_INS_BACK ||
			              cmd_q == CMD_INS_POS) ? count_q + CNT_W'(1) :
			             (st_q == STAT_OK && (cmd_q == CMD_REM_FRONT ||
			              cmd_q == CMD_REM_BACK || cmd_q == CMD_REM_POS)) ?
			             count_q - CNT_W'(1) : count_q);
		end
	end

	// drive ports
	assign cmd_stall      = (state_q != ST_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign removed_value  = removed_q;
	assign found_position = found_q;
	assign length         = length_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("list length beyond capacity");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_we)
		else $error("entry write while idle");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside final state");

	a_count_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(commit))
		else $error("length changed outside commit");

	a_length_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$past(commit) |-> length_q == LEN_W'(count_q))
		else $error("reported length differs from stored length");
`endif

endmodule

`default_nettype wire
